[design/mvwbp_pkg.sv]
// Shared types and constants for the msb-first variable-width bit packer.
// No dependencies; used by every module of the packer.
`timescale 1ns / 1ps
`default_nettype none
package mvwbp_pkg;

    // widths of the input and result words
    localparam int CODE_BITS     = 32;
    localparam int LEN_BITS      = 6;
    localparam int BYTE_BITS     = 8;
    localparam int POS_BITS      = 3;
    localparam int CNT_BITS      = 3;
    localparam int MAX_CODE_BITS = 32;

    // longest code taken by one put; longer lengths saturate here
    localparam int LEN_LIMIT = (MAX_CODE_BITS < CODE_BITS) ? MAX_CODE_BITS : CODE_BITS;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // command carried in tuser
    typedef enum logic {
        CMD_PUT   = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    // one queued run: up to four bytes, earliest byte in the top bits
    typedef struct packed {
        logic [CODE_BITS-1:0] bytes;
        logic [CNT_BITS-1:0]  count;
    } run_t;

endpackage
`default_nettype wire

[design/mvwbp_front.sv]
// Front end of the bit packer: accepts put/flush words, merges code bits
// with the pending partial byte and queues complete bytes. Uses mvwbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvwbp_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              in_valid,
    input  wire logic                              in_cmd,
    input  wire logic [mvwbp_pkg::CODE_BITS-1:0]   in_code,
    input  wire logic [mvwbp_pkg::LEN_BITS-1:0]    in_len,
    input  wire logic                              queue_full,
    output logic                                   in_ready,
    output logic                                   push,
    output mvwbp_pkg::run_t                        push_run
);

    localparam int WIN_BITS = mvwbp_pkg::CODE_BITS + mvwbp_pkg::BYTE_BITS;

    logic [mvwbp_pkg::BYTE_BITS-1:0] pending_reg, pending_next;
    logic [mvwbp_pkg::POS_BITS-1:0]  bitpos_reg, bitpos_next;

    mvwbp_pkg::cmd_t                 cmd;
    logic                            accept;
    logic [mvwbp_pkg::LEN_BITS-1:0]  len_eff;
    logic [mvwbp_pkg::LEN_BITS-1:0]  left_shift;
    logic [mvwbp_pkg::CODE_BITS-1:0] code_left;
    logic [WIN_BITS-1:0]             window;
    logic [mvwbp_pkg::LEN_BITS-1:0]  total;
    logic [mvwbp_pkg::CNT_BITS-1:0]  nbytes;
    logic [mvwbp_pkg::BYTE_BITS-1:0] next_partial;

    assign cmd      = mvwbp_pkg::cmd_t'(in_cmd);
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // saturate the code length
    always_comb begin
        if (in_len > mvwbp_pkg::LEN_BITS'(mvwbp_pkg::LEN_LIMIT)) begin
            len_eff = mvwbp_pkg::LEN_BITS'(mvwbp_pkg::LEN_LIMIT);
        end else begin
            len_eff = in_len;
        end
    end

    // left-align the code, then drop it in right after the pending bits
    assign left_shift = mvwbp_pkg::LEN_BITS'(mvwbp_pkg::CODE_BITS) - len_eff;
    assign code_left  = (len_eff == '0) ? '0 : (in_code << left_shift);
    assign window     = {pending_reg, {mvwbp_pkg::CODE_BITS{1'b0}}}
                      | ({code_left, {mvwbp_pkg::BYTE_BITS{1'b0}}} >> bitpos_reg);
    assign total      = mvwbp_pkg::LEN_BITS'(bitpos_reg) + len_eff;
    assign nbytes     = total[mvwbp_pkg::LEN_BITS-1:mvwbp_pkg::POS_BITS];

    // byte that stays partly filled after the complete ones
    always_comb begin
        unique case (nbytes)
            3'd0:    next_partial = window[39:32];
            3'd1:    next_partial = window[31:24];
            3'd2:    next_partial = window[23:16];
            3'd3:    next_partial = window[15:8];
            3'd4:    next_partial = window[7:0];
            default: next_partial = '0;
        endcase
    end

    // classify the word and build the queue entry
    always_comb begin
        pending_next = pending_reg;
        bitpos_next  = bitpos_reg;
        push         = 1'b0;
        push_run     = '0;
        if (accept) begin
            unique case (cmd)
                mvwbp_pkg::CMD_FLUSH: begin
                    push           = (bitpos_reg != '0);
                    push_run.bytes = {pending_reg, {(mvwbp_pkg::CODE_BITS-8){1'b0}}};
                    push_run.count = mvwbp_pkg::CNT_BITS'(1);
                    pending_next   = '0;
                    bitpos_next    = '0;
                end
                mvwbp_pkg::CMD_PUT: begin
                    push           = (nbytes != '0);
                    push_run.bytes = window[WIN_BITS-1:mvwbp_pkg::BYTE_BITS];
                    push_run.count = nbytes;
                    pending_next   = next_partial;
                    bitpos_next    = total[mvwbp_pkg::POS_BITS-1:0];
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // pending partial byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            bitpos_reg  <= '0;
        end else begin
            pending_reg <= pending_next;
            bitpos_reg  <= bitpos_next;
        end
    end

endmodule
`default_nettype wire

[design/mvwbp_queue.sv]
// Short queue of byte runs between the front and back of the bit packer.
// Uses mvwbp_pkg for the run type and depth.
`timescale 1ns / 1ps
`default_nettype none
module mvwbp_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  mvwbp_pkg::run_t      push_run,
    input  wire logic            pop,
    output logic                 full,
    output logic                 empty,
    output mvwbp_pkg::run_t      head_run
);

    mvwbp_pkg::run_t                 mem [mvwbp_pkg::QUEUE_DEPTH];
    logic [mvwbp_pkg::QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mvwbp_pkg::QPTR_BITS:0]   fill_reg, fill_next;
    logic                            do_push, do_pop;

    assign full     = (fill_reg == (mvwbp_pkg::QPTR_BITS+1)'(mvwbp_pkg::QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_run = mem[rd_ptr_reg];

    // fill level
    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_run;
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule
`default_nettype wire

[design/mvwbp_back.sv]
// Back end of the bit packer: takes queued runs and sends them out one
// byte per word, marking the last byte of each run. Uses mvwbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvwbp_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              q_empty,
    input  mvwbp_pkg::run_t                        q_head,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [mvwbp_pkg::BYTE_BITS-1:0]        out_byte,
    output logic                                   out_last
);

    logic [mvwbp_pkg::CODE_BITS-1:0] word_reg, word_next;
    logic [mvwbp_pkg::CNT_BITS-1:0]  left_reg, left_next;
    logic                            take;

    assign out_valid = (left_reg != '0);
    assign out_byte  = word_reg[mvwbp_pkg::CODE_BITS-1 -: mvwbp_pkg::BYTE_BITS];
    assign out_last  = (left_reg == mvwbp_pkg::CNT_BITS'(1));
    assign take      = out_valid && out_ready;

    // load a new run once the current one is done or finishing
    assign q_pop = !q_empty && (!out_valid || (take && out_last));

    always_comb begin
        word_next = word_reg;
        left_next = left_reg;
        if (q_pop) begin
            word_next = q_head.bytes;
            left_next = q_head.count;
        end else if (take) begin
            word_next = word_reg << mvwbp_pkg::BYTE_BITS;
            left_next = left_reg - 1'b1;
        end
    end

    // output shift register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
        word_reg <= word_next;
    end

endmodule
`default_nettype wire

[design/msb_first_variable_width_bit_packer.sv]
// Path: a word's first byte goes through the run queue and then the output shift register.
// Throughput: the back end sends one byte per cycle while m_tready is high; a put
// or flush word that completes k bytes (1 to 4) queues one run of k bytes, one that
// completes none queues nothing. A four-run queue sets the slack.
// Reset: aresetn, synchronous, clears the pending bits, the queue and output.
// Top level of the msb-first bit packer; uses mvwbp_pkg, front, queue, back.
`timescale 1ns / 1ps
`default_nettype none
module msb_first_variable_width_bit_packer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] code_value, [37:32] code_length
    input  wire logic        s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast    // last_of_run
);

    mvwbp_pkg::run_t push_run, head_run;
    logic            push, pop, q_full, q_empty;

    // classify and merge
    mvwbp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_cmd     (s_tuser),
        .in_code    (s_tdata[31:0]),
        .in_len     (s_tdata[37:32]),
        .queue_full (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_run   (push_run)
    );

    // decouple front and back
    mvwbp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_run (head_run)
    );

    // byte output
    mvwbp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (head_run),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
`default_nettype wire

[design/mvwbp_checker.sv]
// Port-level checks for the msb-first bit packer, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module mvwbp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);

    // a stalled byte stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // a stalled byte keeps its value and mark
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("m_tdata or m_tlast changed while stalled");

    // bytes of one run follow each other without a gap
    a_run_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a byte run");

    // reset empties the output
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind msb_first_variable_width_bit_packer mvwbp_checker u_mvwbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the msb-first variable-width bit packer.
// Depends on mvwbp_pkg and msb_first_variable_width_bit_packer; a scoreboard
// class predicts the packed bytes, plain tasks drive the stream ports.
`timescale 1ns / 1ps
module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 296;
    localparam int HOLD_AFTER   = 120;   // words taken before the long stall
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 16;

    // bit-level model of the packer plus the queue of bytes still due
    class packer_scoreboard;
        typedef struct packed {
            logic [7:0] data;
            logic       last;
        } byte_due_t;

        byte_due_t   bytes_due[$];
        logic [7:0]  partial_byte;
        int          fill_count;
        int          errors;
        int          bytes_seen;

        function new();
            partial_byte = '0;
            fill_count   = 0;
            errors       = 0;
            bytes_seen   = 0;
        endfunction

        // shift one accepted word into the model and queue the bytes it completes
        function void note_word(mvwbp_pkg::cmd_t cmd, logic [31:0] code, logic [5:0] len);
            int take;
            int k;
            int made;
            byte_due_t fresh;
            made = 0;
            take = (len > mvwbp_pkg::LEN_LIMIT) ? mvwbp_pkg::LEN_LIMIT : int'(len);
            if (cmd == mvwbp_pkg::CMD_FLUSH) begin
                if (fill_count != 0) begin
                    fresh.data = partial_byte;
                    fresh.last = 1'b0;
                    bytes_due.push_back(fresh);
                    made++;
                end
                partial_byte = '0;
                fill_count   = 0;
            end else begin
                for (k = take - 1; k >= 0; k--) begin
                    partial_byte[7 - fill_count] = code[k];
                    fill_count++;
                    if (fill_count == 8) begin
                        fresh.data = partial_byte;
                        fresh.last = 1'b0;
                        bytes_due.push_back(fresh);
                        made++;
                        partial_byte = '0;
                        fill_count   = 0;
                    end
                end
            end
            // mark the final byte of this word
            if (made > 0)
                bytes_due[bytes_due.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            $display("tb_top: mismatch: %s", msg);
            errors++;
        endtask

        // compare one delivered byte against the oldest one due
        task check_byte(logic [7:0] data, logic last);
            byte_due_t want;
            bytes_seen++;
            if (bytes_due.size() == 0) begin
                report($sformatf("byte %0d: got %02h last %0b with nothing due",
                                 bytes_seen, data, last));
            end else begin
                want = bytes_due.pop_front();
                if (data !== want.data)
                    report($sformatf("byte %0d: data %02h, want %02h",
                                     bytes_seen, data, want.data));
                if (last !== want.last)
                    report($sformatf("byte %0d: last %0b, want %0b",
                                     bytes_seen, last, want.last));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [31:0] code_value, [37:32] code_length, [39:38] zero
    logic        s_tuser;   // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic        m_tlast;   // last_of_run

    packer_scoreboard book = new();

    int words_taken;
    int flushes_taken;
    int saturated_puts;
    int burst_left;
    int cycle_count;

    msb_first_variable_width_bit_packer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock and reset
    initial begin
        aclk    = 1'b0;
        aresetn = 1'b0;
        fork
            forever #5 aclk = ~aclk;
            begin
                repeat (12) @(posedge aclk);
                @(negedge aclk);
                aresetn <= 1'b1;
            end
        join_none
    end

    // cycle counter and timeout
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top: timeout with %0d bytes still due", book.bytes_due.size());
        $display("tb_top: errors");
        $finish;
    end

    // receiver: stall segments of random density, one long hold-off
    initial begin : receiver
        int seg_left;
        int stall_pct;
        int hold_count;
        bit hold_done;
        seg_left  = 0;
        stall_pct = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && words_taken >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                m_tready  <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(negedge aclk);
                    hold_count++;
                end
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(16, 64);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                seg_left--;
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            book.check_byte(m_tdata, m_tlast);
    end

    // offer one word and hold it until taken
    task send_word(mvwbp_pkg::cmd_t cmd, logic [31:0] code, logic [5:0] len);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, len, code};
        do
            @(posedge aclk);
        while (!s_tready);
        book.note_word(cmd, code, len);
        words_taken++;
        if (cmd == mvwbp_pkg::CMD_FLUSH)
            flushes_taken++;
        else if (len > mvwbp_pkg::LEN_LIMIT)
            saturated_puts++;
    endtask

    // sender pacing: bursts of back-to-back words, sometimes separated by idle gaps
    task offer_word(mvwbp_pkg::cmd_t cmd, logic [31:0] code, logic [5:0] len);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        send_word(cmd, code, len);
    endtask

    // code lengths: mostly legal, some typical lzw widths, zero and overlong
    function logic [5:0] pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 6'd0;
        else if (roll < 20)
            return 6'($urandom_range(9, 12));
        else if (roll < 32)
            return 6'($urandom_range(33, 63));
        else
            return 6'($urandom_range(1, 32));
    endfunction

    initial begin : stimulus
        int n;
        s_tvalid       = 1'b0;
        s_tuser        = mvwbp_pkg::CMD_PUT;
        s_tdata        = '0;
        words_taken    = 0;
        flushes_taken  = 0;
        saturated_puts = 0;
        burst_left     = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);

        // directed: empty flush, zero length, partial bytes, full words, saturation
        offer_word(mvwbp_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 6'd63);
        offer_word(mvwbp_pkg::CMD_PUT,   32'hFFFF_FFFF, 6'd0);
        offer_word(mvwbp_pkg::CMD_PUT,   32'h0000_0001, 6'd1);
        offer_word(mvwbp_pkg::CMD_PUT,   32'hFFFF_FF55, 6'd7);
        offer_word(mvwbp_pkg::CMD_PUT,   32'hFFFF_FFFF, 6'd32);
        offer_word(mvwbp_pkg::CMD_PUT,   32'h0000_0000, 6'd32);
        offer_word(mvwbp_pkg::CMD_PUT,   32'hA5C3_5A3C, 6'd63);
        offer_word(mvwbp_pkg::CMD_PUT,   32'h8000_0001, 6'd33);
        offer_word(mvwbp_pkg::CMD_PUT,   32'h0000_0005, 6'd3);
        offer_word(mvwbp_pkg::CMD_FLUSH, 32'h0000_0000, 6'd0);
        offer_word(mvwbp_pkg::CMD_FLUSH, 32'h1234_5678, 6'd17);
        offer_word(mvwbp_pkg::CMD_PUT,   32'hFFFF_FFFF, 6'd4);
        offer_word(mvwbp_pkg::CMD_PUT,   32'h0000_8001, 6'd16);
        offer_word(mvwbp_pkg::CMD_PUT,   32'h0000_00FF, 6'd8);
        offer_word(mvwbp_pkg::CMD_PUT,   32'h7FFF_FFFE, 6'd31);
        offer_word(mvwbp_pkg::CMD_PUT,   32'h0000_0013, 6'd5);
        offer_word(mvwbp_pkg::CMD_PUT,   32'hDEAD_BEEF, 6'd32);
        offer_word(mvwbp_pkg::CMD_PUT,   32'h0000_0001, 6'd1);
        offer_word(mvwbp_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 6'd32);
        offer_word(mvwbp_pkg::CMD_PUT,   32'h5555_5555, 6'd32);
        offer_word(mvwbp_pkg::CMD_PUT,   32'hAAAA_AAAA, 6'd32);
        offer_word(mvwbp_pkg::CMD_PUT,   32'h0000_0FFF, 6'd12);
        offer_word(mvwbp_pkg::CMD_FLUSH, 32'h0000_0000, 6'd0);

        // random: code streams with occasional flushes
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if ($urandom_range(0, 99) < 10)
                offer_word(mvwbp_pkg::CMD_FLUSH, $urandom(), 6'($urandom_range(0, 63)));
            else
                offer_word(mvwbp_pkg::CMD_PUT, $urandom(), pick_length());
        end
        offer_word(mvwbp_pkg::CMD_FLUSH, 32'h0000_0000, 6'd0);

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        while (book.bytes_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb_top: %0d words taken (%0d flushes, %0d overlong puts), %0d bytes checked",
                 words_taken, flushes_taken, saturated_puts, book.bytes_seen);
        $display("tb_top: %0d cycles including a %0d-cycle output hold-off",
                 cycle_count, HOLD_CYCLES);
        if (book.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
